// File: src/frame_to_ascii_glyphs_defines.svh
// ----------------------------------------------------------------------------
// frame_to_ascii_glyphs assertion macros
// Shared concurrent-check shorthands; each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef FRAME_TO_ASCII_GLYPHS_DEFINES_SVH
`define FRAME_TO_ASCII_GLYPHS_DEFINES_SVH

// condition holds at every edge out of reset
`define F2AG_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define F2AG_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define F2AG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/f2ag_pkg.sv
// ----------------------------------------------------------------------------
// f2ag_pkg
// Types, sizes and constant tables shared by the frame-to-glyph blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package f2ag_pkg;

  // source frame geometry
  localparam int SRC_WIDTH  = 640;
  localparam int SRC_HEIGHT = 480;
  localparam int COL_W = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
  localparam int ROW_W = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;

  // grid size registers
  localparam int OUT_W_W    = 10;
  localparam int OUT_H_W    = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = CFG_IDX_W'(1);
  localparam logic [OUT_W_W-1:0]   OUT_WIDTH_RESET  = OUT_W_W'(640);
  localparam logic [OUT_H_W-1:0]   OUT_HEIGHT_RESET = OUT_H_W'(480);

  // column mapping: x = ceil(t*ow / SRC_WIDTH), done as (t*ow + W-1) * KX >> SX
  localparam int PX_W  = COL_W + OUT_W_W;
  localparam int NX_W  = PX_W + 1;
  localparam int SX    = $clog2(SRC_WIDTH) + NX_W;
  localparam int KX_W  = NX_W + 2;
  localparam int PRX_W = NX_W + KX_W;
  localparam logic [KX_W-1:0] KX =
    KX_W'(((64'd1 << SX) + 64'(SRC_WIDTH) - 64'd1) / 64'(SRC_WIDTH));
  localparam int XW_W  = OUT_W_W + COL_W + 1;

  // row mapping: y = floor(((r+1)*oh - 1) / SRC_HEIGHT)
  localparam int RQ_W  = ROW_W + OUT_H_W;
  localparam int NY_W  = RQ_W + 1;
  localparam int SY    = $clog2(SRC_HEIGHT) + NY_W;
  localparam int KY_W  = NY_W + 2;
  localparam int PRY_W = NY_W + KY_W;
  localparam logic [KY_W-1:0] KY =
    KY_W'(((64'd1 << SY) + 64'(SRC_HEIGHT) - 64'd1) / 64'(SRC_HEIGHT));
  localparam int YH_W  = OUT_H_W + ROW_W + 1;

  // luma = floor((299r + 587g + 114b) / 1000)
  localparam int LUMA_KR  = 299;
  localparam int LUMA_KG  = 587;
  localparam int LUMA_KB  = 114;
  localparam int LUMA_DIV = 1000;
  localparam int SUM_W    = 18;
  localparam int SL       = $clog2(LUMA_DIV) + SUM_W;
  localparam int KL_W     = SUM_W + 2;
  localparam int PRL_W    = SUM_W + KL_W;
  localparam logic [KL_W-1:0] KL =
    KL_W'(((64'd1 << SL) + 64'(LUMA_DIV) - 64'd1) / 64'(LUMA_DIV));

  // glyph ramp, darkest cell first
  localparam int RAMP_LEN = 23;
  localparam int LUMA_MAX = 255;
  localparam logic [RAMP_LEN*8-1:0] RAMP = " .,:;irsXA253hMHGS#9B&@";

  typedef logic [255:0][6:0] glyph_lut_t;

  function automatic glyph_lut_t build_glyph_lut();
    glyph_lut_t lut;
    int         idx;
    for (int i = 0; i < 256; i++) begin
      idx    = ((LUMA_MAX - i) * (RAMP_LEN - 1)) / LUMA_MAX;
      lut[i] = RAMP[(RAMP_LEN - 1 - idx) * 8 +: 7];
    end
    return lut;
  endfunction

  localparam glyph_lut_t GLYPH_LUT = build_glyph_lut();

  // queue between front and back
  localparam int QPTR_W = 3;
  localparam int QDEPTH = 1 << QPTR_W;
  localparam int QCNT_W = QPTR_W + 1;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [6:0]         glyph;
    logic [OUT_H_W-1:0] cell_row;
    logic [OUT_W_W-1:0] cell_col;
    logic               frame_last;
  } result_t;

  typedef struct packed {
    pixel_t             pixel;
    logic [OUT_H_W-1:0] row;
    logic [OUT_W_W-1:0] col;
    logic               last;
  } cell_t;

  typedef struct packed {
    logic  valid;
    cell_t entry;
  } qwr_t;

endpackage

`default_nettype wire

// File: src/f2ag_front.sv
// ----------------------------------------------------------------------------
// f2ag_front
// Raster counters, grid size registers and the pixel-to-cell mapping pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module f2ag_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  f2ag_pkg::pixel_t                    pixel,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [f2ag_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [f2ag_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [f2ag_pkg::QCNT_W-1:0]         q_fill,
  output f2ag_pkg::qwr_t                      q_wr
);

  logic [f2ag_pkg::OUT_W_W-1:0] out_width;
  logic [f2ag_pkg::OUT_H_W-1:0] out_height;
  logic [f2ag_pkg::COL_W-1:0]   source_column;
  logic [f2ag_pkg::ROW_W-1:0]   source_row;
  logic                         accept;

  // stage A: mirrored column, row, effective sizes
  logic                         a_valid;
  f2ag_pkg::pixel_t             a_pixel;
  logic [f2ag_pkg::COL_W-1:0]   a_t;
  logic [f2ag_pkg::ROW_W-1:0]   a_r;
  logic [f2ag_pkg::OUT_W_W-1:0] a_ow;
  logic [f2ag_pkg::OUT_H_W-1:0] a_oh;

  // stage B: products
  logic                         b_valid;
  f2ag_pkg::pixel_t             b_pixel;
  logic [f2ag_pkg::PX_W-1:0]    b_p;
  logic [f2ag_pkg::RQ_W-1:0]    b_rq;
  logic [f2ag_pkg::OUT_W_W-1:0] b_ow;
  logic [f2ag_pkg::OUT_H_W-1:0] b_oh;

  // stage C: dividends
  logic                         c_valid;
  f2ag_pkg::pixel_t             c_pixel;
  logic [f2ag_pkg::PX_W-1:0]    c_p;
  logic [f2ag_pkg::RQ_W-1:0]    c_rq;
  logic [f2ag_pkg::NX_W-1:0]    c_nx;
  logic [f2ag_pkg::NY_W-1:0]    c_ny;
  logic [f2ag_pkg::OUT_W_W-1:0] c_ow;
  logic [f2ag_pkg::OUT_H_W-1:0] c_oh;
  logic [f2ag_pkg::PRX_W-1:0]   prod_x;
  logic [f2ag_pkg::PRY_W-1:0]   prod_y;

  // stage D: candidate cell
  logic                         d_valid;
  f2ag_pkg::pixel_t             d_pixel;
  logic [f2ag_pkg::PX_W-1:0]    d_p;
  logic [f2ag_pkg::RQ_W-1:0]    d_rq;
  logic [f2ag_pkg::OUT_W_W-1:0] d_x;
  logic [f2ag_pkg::OUT_H_W-1:0] d_y;
  logic [f2ag_pkg::OUT_W_W-1:0] d_ow;
  logic [f2ag_pkg::OUT_H_W-1:0] d_oh;

  // hit test
  logic [f2ag_pkg::OUT_H_W-1:0] y_max;
  logic [f2ag_pkg::OUT_H_W-1:0] y_c;
  logic [f2ag_pkg::XW_W-1:0]    xw;
  logic [f2ag_pkg::XW_W-1:0]    diff_x;
  logic [f2ag_pkg::YH_W-1:0]    yh;
  logic                         hit_x;
  logic                         hit_y;
  logic [f2ag_pkg::QCNT_W:0]    reserved;

  assign cfg_ready = 1'b1;

  // every item in flight holds a queue slot until it lands or misses
  assign reserved = {1'b0, q_fill}
                  + (f2ag_pkg::QCNT_W+1)'(a_valid) + (f2ag_pkg::QCNT_W+1)'(b_valid)
                  + (f2ag_pkg::QCNT_W+1)'(c_valid) + (f2ag_pkg::QCNT_W+1)'(d_valid);
  assign full   = (reserved >= (f2ag_pkg::QCNT_W+1)'(f2ag_pkg::QDEPTH));
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_width  <= f2ag_pkg::OUT_WIDTH_RESET;
      out_height <= f2ag_pkg::OUT_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        f2ag_pkg::REG_OUT_WIDTH:  out_width  <= cfg_data[f2ag_pkg::OUT_W_W-1:0];
        f2ag_pkg::REG_OUT_HEIGHT: out_height <= cfg_data[f2ag_pkg::OUT_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_column <= '0;
      source_row    <= '0;
    end else if (accept) begin
      if (source_column == f2ag_pkg::COL_W'(f2ag_pkg::SRC_WIDTH - 1)) begin
        source_column <= '0;
        if (source_row == f2ag_pkg::ROW_W'(f2ag_pkg::SRC_HEIGHT - 1)) begin
          source_row <= '0;
        end else begin
          source_row <= source_row + 1'b1;
        end
      end else begin
        source_column <= source_column + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  assign prod_x = f2ag_pkg::PRX_W'(c_nx) * f2ag_pkg::PRX_W'(f2ag_pkg::KX);
  assign prod_y = f2ag_pkg::PRY_W'(c_ny) * f2ag_pkg::PRY_W'(f2ag_pkg::KY);

  always_ff @(posedge clk) begin
    a_pixel <= pixel;
    a_t     <= f2ag_pkg::COL_W'(f2ag_pkg::SRC_WIDTH - 1) - source_column;
    a_r     <= source_row;
    a_ow    <= (out_width == '0) ? f2ag_pkg::OUT_W_W'(1) : out_width;
    a_oh    <= (out_height == '0) ? f2ag_pkg::OUT_H_W'(1) : out_height;

    b_pixel <= a_pixel;
    b_p     <= f2ag_pkg::PX_W'(a_t) * f2ag_pkg::PX_W'(a_ow);
    b_rq    <= f2ag_pkg::RQ_W'(a_r) * f2ag_pkg::RQ_W'(a_oh);
    b_ow    <= a_ow;
    b_oh    <= a_oh;

    c_pixel <= b_pixel;
    c_p     <= b_p;
    c_rq    <= b_rq;
    c_nx    <= f2ag_pkg::NX_W'(b_p) + f2ag_pkg::NX_W'(f2ag_pkg::SRC_WIDTH - 1);
    c_ny    <= f2ag_pkg::NY_W'(b_rq) + f2ag_pkg::NY_W'(b_oh) - f2ag_pkg::NY_W'(1);
    c_ow    <= b_ow;
    c_oh    <= b_oh;

    d_pixel <= c_pixel;
    d_p     <= c_p;
    d_rq    <= c_rq;
    d_x     <= prod_x[f2ag_pkg::SX +: f2ag_pkg::OUT_W_W];
    d_y     <= prod_y[f2ag_pkg::SY +: f2ag_pkg::OUT_H_W];
    d_ow    <= c_ow;
    d_oh    <= c_oh;
  end

  // x is a ceiling, so x*W - t*ow is the rounding slack; a hit needs slack < ow
  assign y_max  = d_oh - f2ag_pkg::OUT_H_W'(1);
  assign y_c    = (d_y > y_max) ? y_max : d_y;
  assign xw     = f2ag_pkg::XW_W'(d_x) * f2ag_pkg::XW_W'(f2ag_pkg::SRC_WIDTH);
  assign diff_x = xw - f2ag_pkg::XW_W'(d_p);
  assign hit_x  = (d_x < d_ow) && (diff_x < f2ag_pkg::XW_W'(d_ow));
  assign yh     = f2ag_pkg::YH_W'(y_c) * f2ag_pkg::YH_W'(f2ag_pkg::SRC_HEIGHT);
  assign hit_y  = (yh >= f2ag_pkg::YH_W'(d_rq))
               && (yh < f2ag_pkg::YH_W'(d_rq) + f2ag_pkg::YH_W'(d_oh));

  assign q_wr.valid       = d_valid && hit_x && hit_y;
  assign q_wr.entry.pixel = d_pixel;
  assign q_wr.entry.row   = y_c;
  assign q_wr.entry.col   = d_x;
  assign q_wr.entry.last  = (y_c == y_max) && (d_x == '0);

endmodule

`default_nettype wire

// File: src/f2ag_queue.sv
// ----------------------------------------------------------------------------
// f2ag_queue
// Short FIFO of mapped cells between the front and back pipelines.
// ----------------------------------------------------------------------------
`default_nettype none
`include "frame_to_ascii_glyphs_defines.svh"

module f2ag_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  f2ag_pkg::qwr_t              wr,
  input  logic                        rd,
  output f2ag_pkg::cell_t             head,
  output logic [f2ag_pkg::QCNT_W-1:0] fill
);

  f2ag_pkg::cell_t              mem [f2ag_pkg::QDEPTH];
  logic [f2ag_pkg::QPTR_W-1:0]  wr_ptr;
  logic [f2ag_pkg::QPTR_W-1:0]  rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr.valid, rd})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr.valid) begin
      mem[wr_ptr] <= wr.entry;
    end
  end

  assign head = mem[rd_ptr];

  `F2AG_ASSERT_HOLDS(a_fill_range, fill <= f2ag_pkg::QCNT_W'(f2ag_pkg::QDEPTH), "queue fill out of range")
  `F2AG_ASSERT_IMPLIES(a_no_overflow, fill == f2ag_pkg::QCNT_W'(f2ag_pkg::QDEPTH), !wr.valid, "write into full queue")
  `F2AG_ASSERT_IMPLIES(a_no_underflow, rd, fill != '0, "read from empty queue")
  `F2AG_ASSERT_NEXT(a_fill_drop, rd && !wr.valid, fill == $past(fill) - f2ag_pkg::QCNT_W'(1), "fill did not drop on read")

endmodule

`default_nettype wire

// File: src/f2ag_back.sv
// ----------------------------------------------------------------------------
// f2ag_back
// Luma, glyph lookup and the result register, as a stallable pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module f2ag_back (
  input  logic                        clk,
  input  logic                        rst,
  input  f2ag_pkg::cell_t             q_head,
  input  logic [f2ag_pkg::QCNT_W-1:0] q_fill,
  output logic                        q_rd,
  input  logic                        pop,
  output logic                        empty,
  output f2ag_pkg::result_t           result
);

  logic                          v1;
  logic                          v2;
  logic                          v3;
  logic                          en1;
  logic                          en2;
  logic                          en3;
  logic [f2ag_pkg::SUM_W-1:0]    s1_sum;
  logic [f2ag_pkg::OUT_H_W-1:0]  s1_row;
  logic [f2ag_pkg::OUT_W_W-1:0]  s1_col;
  logic                          s1_last;
  logic [7:0]                    s2_luma;
  logic [f2ag_pkg::OUT_H_W-1:0]  s2_row;
  logic [f2ag_pkg::OUT_W_W-1:0]  s2_col;
  logic                          s2_last;
  logic [f2ag_pkg::PRL_W-1:0]    prod_l;

  // a stage loads when it is empty or its successor moves
  assign en3  = !v3 || pop;
  assign en2  = !v2 || en3;
  assign en1  = !v1 || en2;
  assign q_rd = en1 && (q_fill != '0);

  assign prod_l = f2ag_pkg::PRL_W'(s1_sum) * f2ag_pkg::PRL_W'(f2ag_pkg::KL);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= q_rd;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_sum  <= f2ag_pkg::SUM_W'(q_head.pixel.red)   * f2ag_pkg::SUM_W'(f2ag_pkg::LUMA_KR)
               + f2ag_pkg::SUM_W'(q_head.pixel.green) * f2ag_pkg::SUM_W'(f2ag_pkg::LUMA_KG)
               + f2ag_pkg::SUM_W'(q_head.pixel.blue)  * f2ag_pkg::SUM_W'(f2ag_pkg::LUMA_KB);
      s1_row  <= q_head.row;
      s1_col  <= q_head.col;
      s1_last <= q_head.last;
    end
    if (en2) begin
      s2_luma <= prod_l[f2ag_pkg::SL +: 8];
      s2_row  <= s1_row;
      s2_col  <= s1_col;
      s2_last <= s1_last;
    end
    if (en3) begin
      result.glyph      <= f2ag_pkg::GLYPH_LUT[s2_luma];
      result.cell_row   <= s2_row;
      result.cell_col   <= s2_col;
      result.frame_last <= s2_last;
    end
  end

  assign empty = !v3;

endmodule

`default_nettype wire

// File: src/frame_to_ascii_glyphs.sv
// ----------------------------------------------------------------------------
// frame_to_ascii_glyphs
// Raster BGR pixels in, mirrored nearest-neighbor ASCII glyph cells out.
// ----------------------------------------------------------------------------
//   Input channel: one pixel beat (blue, green, red) per push, taken when push
//   is high and full is low, in raster order; the block counts column and row
//   itself and wraps at frame end.
//   Result channel: queue style. While empty is low the oldest glyph cell sits
//   on result; pop takes it. Pixels that feed no cell give no beat.
//   Config channel: cfg_index 0 = out_width, 1 = out_height, other indexes are
//   dropped; cfg_ready is always high, a size of 0 acts as 1. New sizes apply
//   from the next accepted pixel.
//   Throughput: one pixel per cycle while full stays low. Path from the
//   accepting edge to result when pop keeps up: mirrored column and sizes,
//   products, dividends and the reciprocal multiply, hit test into the
//   8-entry queue, then luma sum, luma divide and glyph lookup.
//   Stall: with pop low the back pipeline and queue fill; full rises once the
//   queue plus the 4 front stages hold 8 beats, so nothing is ever dropped.
//   Reset (rst, synchronous): counters to origin, sizes 640x480, all emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_to_ascii_glyphs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  f2ag_pkg::pixel_t                pixel,
  output logic                            empty,
  input  logic                            pop,
  output f2ag_pkg::result_t               result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [f2ag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [f2ag_pkg::CFG_DATA_W-1:0] cfg_data
);

  // front -> queue write beat
  f2ag_pkg::qwr_t              q_wr;
  // queue -> back head and occupancy
  f2ag_pkg::cell_t             q_head;
  logic [f2ag_pkg::QCNT_W-1:0] q_fill;
  logic                        q_rd;

  // Front: counters, size registers and the cell mapping; reserves a queue
  // slot for every pixel in flight so it never has to stall mid-pipe.
  f2ag_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .pixel     (pixel),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_fill    (q_fill),
    .q_wr      (q_wr)
  );

  // Queue decouples the free-running front from the stallable back.
  f2ag_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_wr),
    .rd   (q_rd),
    .head (q_head),
    .fill (q_fill)
  );

  // Back: luma, ramp lookup, result register; stalls on pop.
  f2ag_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_head (q_head),
    .q_fill (q_fill),
    .q_rd   (q_rd),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

endmodule

`default_nettype wire

// File: sim/glyph_cell_checker.sv
// ----------------------------------------------------------------------------
// glyph_cell_checker
// Watches the pixel, glyph and size channels of frame_to_ascii_glyphs, keeps
// its own raster position and grid size, predicts each glyph cell and compares
// every popped beat with the oldest prediction.
// ----------------------------------------------------------------------------
module glyph_cell_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            full,
  input  f2ag_pkg::pixel_t                pixel,
  input  logic                            empty,
  input  logic                            pop,
  input  f2ag_pkg::result_t               result,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [f2ag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [f2ag_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              cells_pending
);

  import f2ag_pkg::*;

  localparam int MAX_REPORTS = 10;

  logic [OUT_W_W-1:0] grid_cols;
  logic [OUT_H_W-1:0] grid_rows;
  int unsigned        src_col;
  int unsigned        src_row;
  result_t            expected_cells[$];

  // Mirrored nearest-neighbor pick: smallest grid column, largest grid row
  // fed by this source pixel. Returns 0 when the pixel feeds no cell.
  function automatic bit map_pixel(input pixel_t px, input int unsigned col,
                                   input int unsigned row,
                                   input logic [OUT_W_W-1:0] cols_reg,
                                   input logic [OUT_H_W-1:0] rows_reg,
                                   output result_t beat);
    longint unsigned ow, oh, t, x, y, luma;
    int unsigned     level;
    bit              hit;
    ow  = (cols_reg == '0) ? 1 : cols_reg;
    oh  = (rows_reg == '0) ? 1 : rows_reg;
    t   = SRC_WIDTH - 1 - col;
    x   = (t * ow + SRC_WIDTH - 1) / SRC_WIDTH;
    hit = (x < ow) && (x * SRC_WIDTH < (t + 1) * ow);
    y   = ((row + 1) * oh - 1) / SRC_HEIGHT;
    if (y > oh - 1) y = oh - 1;
    if (y * SRC_HEIGHT < row * oh || y * SRC_HEIGHT >= (row + 1) * oh) hit = 1'b0;
    luma  = (LUMA_KR * px.red + LUMA_KG * px.green + LUMA_KB * px.blue) / LUMA_DIV;
    level = 32'(((LUMA_MAX - luma) * (RAMP_LEN - 1)) / LUMA_MAX);
    if (level >= RAMP_LEN) level = RAMP_LEN - 1;
    beat.glyph      = RAMP[(RAMP_LEN - 1 - level) * 8 +: 7];
    beat.cell_row   = y[OUT_H_W-1:0];
    beat.cell_col   = x[OUT_W_W-1:0];
    beat.frame_last = (y == oh - 1) && (x == 0);
    return hit;
  endfunction

  always @(posedge clk) begin : track
    result_t want;
    result_t mapped;
    if (rst) begin
      grid_cols  = OUT_WIDTH_RESET;
      grid_rows  = OUT_HEIGHT_RESET;
      src_col    = 0;
      src_row    = 0;
      mismatches = 0;
      expected_cells.delete();
    end else begin
      // pop side first: a beat leaving now was predicted at an earlier edge
      if (pop && !empty) begin
        if (expected_cells.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected glyph beat glyph %0d row %0d col %0d last %0b",
                     $time, result.glyph, result.cell_row, result.cell_col,
                     result.frame_last);
        end else begin
          want = expected_cells.pop_front();
          if (result.glyph !== want.glyph || result.cell_row !== want.cell_row ||
              result.cell_col !== want.cell_col ||
              result.frame_last !== want.frame_last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: exp/got glyph %0d/%0d row %0d/%0d col %0d/%0d last %0b/%0b",
                       $time, want.glyph, result.glyph, want.cell_row,
                       result.cell_row, want.cell_col, result.cell_col,
                       want.frame_last, result.frame_last);
          end
        end
      end
      if (push && !full) begin
        if (map_pixel(pixel, src_col, src_row, grid_cols, grid_rows, mapped))
          expected_cells.push_back(mapped);
        if (src_col == SRC_WIDTH - 1) begin
          src_col = 0;
          src_row = (src_row == SRC_HEIGHT - 1) ? 0 : src_row + 1;
        end else begin
          src_col++;
        end
      end
      // new sizes apply from the next pixel
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OUT_WIDTH:  grid_cols = cfg_data[OUT_W_W-1:0];
          REG_OUT_HEIGHT: grid_rows = cfg_data[OUT_H_W-1:0];
          default: ;
        endcase
      end
    end
    cells_pending = expected_cells.size();
  end

endmodule

// File: sim/tb_frame_to_ascii_glyphs.sv
// ----------------------------------------------------------------------------
// tb_frame_to_ascii_glyphs
// Drives raster pixels and grid sizes into frame_to_ascii_glyphs with random
// stalls on both sides; a checker beside the block predicts every glyph beat.
// ----------------------------------------------------------------------------
module tb_frame_to_ascii_glyphs;

  import f2ag_pkg::*;

  localparam int HALF_PERIOD     = 5;
  localparam int RANDOM_PIXELS   = 450;
  localparam int HOLD_OFF_CYCLES = 48;   // long pop stall, well past queue depth
  localparam int SETTLE_CYCLES   = 16;   // outlasts the pipeline from pixel to result
  localparam int WATCHDOG_LIMIT  = 1000; // cycles with no beat on any channel
  localparam int TAIL_PIXELS     = 100;  // closing run on the full grid

  // indexes past the register list, the block must drop these
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  // Directed pixels {blue, green, red}: black, white, each primary alone,
  // alternating bit patterns, then grays at ramp steps (gray g has luma g):
  // 244/243 split index 0 and 1, 12/11 split index 20 and 21, plus mid gray.
  localparam int NUM_DIRECTED = 12;
  localparam logic [NUM_DIRECTED*24-1:0] DIRECTED_PIXELS = {
    24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000, 24'hAA55AA,
    24'h55AA55, 24'hF4F4F4, 24'hF3F3F3, 24'h0C0C0C, 24'h0B0B0B, 24'h808080
  };

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  push      = 1'b0;
  logic                  full;
  pixel_t                pixel     = '0;
  logic                  empty;
  logic                  pop       = 1'b0;
  result_t               result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int          mismatches;
  int          cells_pending;
  bit          gaps_on      = 1'b1;  // random idle bursts on both sides
  bit          hold_off_req = 1'b0;  // receiver takes one long stall
  int unsigned pixels_sent  = 0;     // accepted pixels, tracks raster position
  int          quiet_cycles = 0;

  always #HALF_PERIOD clk = ~clk;

  frame_to_ascii_glyphs uut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .pixel     (pixel),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  glyph_cell_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .pixel         (pixel),
    .empty         (empty),
    .pop           (pop),
    .result        (result),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .cells_pending (cells_pending)
  );

  // Watchdog: a long run of cycles with no beat anywhere means the block hung.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Glyph side. Pop stays high except for short random bursts and the one
  // long hold-off, which backs the queue up into the pixel input.
  initial begin : receiver
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        pop <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        n = $urandom_range(1, 3);
        repeat (n) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // One pixel beat; push stays high into the next call when back to back.
  task automatic offer_pixel(input pixel_t p);
    int n;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      n = $urandom_range(1, 3);
      repeat (n) @(posedge clk);
    end
    push  <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (full) @(posedge clk);
    pixels_sent++;
  endtask

  // Stop pushing, wait for every predicted glyph, then let pixels that give
  // no beat clear the pipeline before the sizes change.
  task automatic quiesce();
    push <= 1'b0;
    @(posedge clk);
    while (cells_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Width then height, optionally with a write to an unused index between.
  task automatic set_grid(input logic [CFG_DATA_W-1:0] cols,
                          input logic [CFG_DATA_W-1:0] rows, input bit poke_spare);
    cfg_valid <= 1'b1;
    cfg_index <= REG_OUT_WIDTH;
    cfg_data  <= cols;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (poke_spare) begin
      cfg_index <= ($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO;
      cfg_data  <= CFG_DATA_W'($urandom);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_index <= REG_OUT_HEIGHT;
    cfg_data  <= rows;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    pixel_t                px;
    logic [CFG_DATA_W-1:0] cols;
    logic [CFG_DATA_W-1:0] rows;
    int                    n;
    int                    budget;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset grid is 640x480, so every pixel maps to a cell.
    for (int i = 0; i < NUM_DIRECTED; i++)
      offer_pixel(DIRECTED_PIXELS[(NUM_DIRECTED - 1 - i) * 24 +: 24]);
    // grid larger than the source: cells share pixels, one beat each
    quiesce();
    set_grid(10'h3FF, 10'h3FF, 1'b1);
    repeat (4) begin
      px = 24'($urandom);
      offer_pixel(px);
    end
    // zero sizes act as 1x1: mid-row pixels feed nothing
    quiesce();
    set_grid('0, '0, 1'b1);
    repeat (4) begin
      px = 24'($urandom);
      offer_pixel(px);
    end
    quiesce();
    set_grid(10'd1, 10'd480, 1'b0);
    repeat (4) begin
      px = 24'($urandom);
      offer_pixel(px);
    end

    // Back-pressure: full grid, pop held off while pixels keep coming.
    quiesce();
    set_grid(10'd640, 10'd480, 1'b0);
    gaps_on      = 1'b0;
    hold_off_req = 1'b1;
    repeat (64) begin
      px = 24'($urandom);
      offer_pixel(px);
    end

    // One-row grid over the rest of source row 0: its last row is row 0, so
    // the rightmost source pixel lands on the final cell of the frame.
    quiesce();
    set_grid(10'd3, 10'd1, 1'b0);
    gaps_on = 1'b1;
    n = SRC_WIDTH - int'(pixels_sent);
    repeat (n) begin
      px = 24'($urandom);
      offer_pixel(px);
    end

    // Random phases: fresh sizes each time, counters carry on mid-frame.
    budget = 0;
    while (budget < RANDOM_PIXELS) begin
      quiesce();
      case ($urandom_range(0, 7))
        0:       cols = '0;
        1:       cols = 10'd1;
        2:       cols = 10'd640;
        3:       cols = 10'h3FF;
        default: cols = CFG_DATA_W'($urandom_range(1, 640));
      endcase
      case ($urandom_range(0, 7))
        0:       rows = '0;
        1:       rows = CFG_DATA_W'($urandom_range(1, 3));
        2:       rows = 10'd480;
        3:       rows = 10'h1FF;
        default: rows = CFG_DATA_W'($urandom_range(1, 480));
      endcase
      rows[CFG_DATA_W-1] = 1'($urandom_range(0, 1));  // above the height field
      set_grid(cols, rows, $urandom_range(0, 3) == 0);
      gaps_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(30, 120);
      repeat (n) begin
        px = 24'($urandom);
        offer_pixel(px);
      end
      budget += n;
    end

    // Last part, no idling: full grid, every pixel gives a beat back to back.
    quiesce();
    set_grid(10'd640, 10'd480, 1'b0);
    gaps_on = 1'b0;
    repeat (TAIL_PIXELS) begin
      px = 24'($urandom);
      offer_pixel(px);
    end

    quiesce();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
